FILE: rtl/wsc_pkg.sv
// types and constants shared by the wavetable sound channel
package wsc_pkg;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_LENGTH = 2'd3
    } t_op;

    // register page and wave page, upper twelve address bits
    localparam logic [11:0] REG_PAGE  = 12'hFF1;
    localparam logic [11:0] WAVE_PAGE = 12'hFF3;

    localparam logic [3:0] REG_DAC    = 4'hA;
    localparam logic [3:0] REG_LENGTH = 4'hB;
    localparam logic [3:0] REG_VOLUME = 4'hC;
    localparam logic [3:0] REG_PER_LO = 4'hD;
    localparam logic [3:0] REG_PER_HI = 4'hE;

    localparam int WAVE_DEPTH = 16;
    localparam logic [8:0]  LENGTH_FULL = 9'd256;
    localparam logic [11:0] PERIOD_BASE = 12'd2048;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] sample_level;
        logic       length_running;
        logic       channel_active;
    } t_result;

endpackage

FILE: rtl/wavetable_sound_channel.sv
// wavetable sound channel: bus registers, wave ram, period timer and length counter
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+---------------------------------------------
//  in      | i_in_valid   | o_in_stall   | i_operation, i_address, i_write_data
//  out     | o_out_valid  | i_out_stall  | o_read_data, o_sample_level,
//          |              |              | o_length_running, o_channel_active
//
// one event per cycle while o_in_stall is low: state updates at the accepting edge and the
// result is registered into a two-entry output queue (head plus skid register).
// o_in_stall rises only when both queue entries hold undelivered results.
// reset is synchronous, active low; it clears all channel state and the wave ram.
module wavetable_sound_channel (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wsc_pkg::t_op        i_operation,
    input  logic [15:0]         i_address,
    input  logic [7:0]          i_write_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [7:0]          o_read_data,
    output logic [3:0]          o_sample_level,
    output logic                o_length_running,
    output logic                o_channel_active
);
    import wsc_pkg::*;

    logic        r_dac_on,   n_dac_on;
    logic        r_ch_on,    n_ch_on;
    logic [8:0]  r_len,      n_len;
    logic        r_gate,     n_gate;
    logic        r_trig,     n_trig;
    logic [1:0]  r_vol,      n_vol;
    logic [10:0] r_per,      n_per;
    logic [12:0] r_timer,    n_timer;
    logic [4:0]  r_pos,      n_pos;
    logic [3:0]  r_level,    n_level;
    logic [7:0]  r_wave [WAVE_DEPTH];

    logic        r_hd_valid, r_sk_valid;
    t_result     r_hd, r_sk;

    logic        w_push, w_pop;
    logic        w_reg_hit, w_wave_hit, w_wave_we;
    logic [12:0] w_reload;
    logic [4:0]  w_step_pos;
    logic [3:0]  w_ridx;
    logic [7:0]  w_byte;
    logic [3:0]  w_nib;
    logic [1:0]  w_shift;
    t_result     w_res;

    assign o_in_stall = r_sk_valid;
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = r_hd_valid && !i_out_stall;

    assign w_reg_hit  = (i_address[15:4] == REG_PAGE) &&
                        (i_address[3:0] >= REG_DAC) && (i_address[3:0] <= REG_PER_HI);
    assign w_wave_hit = (i_address[15:4] == WAVE_PAGE);
    assign w_wave_we  = w_push && (i_operation == OP_WRITE) && w_wave_hit;

    // position after a sample tick, before the level lookup
    assign w_step_pos = (r_timer <= 13'd1) ? r_pos + 5'd1 : r_pos;

    // single wave ram read port, shared between bus reads and sample ticks
    assign w_ridx  = (i_operation == OP_SAMPLE) ? w_step_pos[4:1] : i_address[3:0];
    assign w_byte  = r_wave[w_ridx];
    assign w_nib   = w_step_pos[0] ? w_byte[3:0] : w_byte[7:4];
    assign w_shift = r_vol - 2'd1;

    always_comb begin
        n_dac_on = r_dac_on;
        n_ch_on  = r_ch_on;
        n_len    = r_len;
        n_gate   = r_gate;
        n_trig   = r_trig;
        n_vol    = r_vol;
        n_per    = r_per;
        n_timer  = r_timer;
        n_pos    = r_pos;
        n_level  = r_level;
        w_res.read_data = 8'd0;
        // reload uses the period value in force after this event
        w_reload = 13'd0;

        unique case (i_operation)
            OP_READ: begin
                if (w_reg_hit) begin
                    unique case (i_address[3:0])
                        REG_DAC:    w_res.read_data = {r_dac_on, 7'd0};
                        REG_LENGTH: w_res.read_data = 8'(LENGTH_FULL - r_len);
                        REG_VOLUME: w_res.read_data = {1'b0, r_vol, 5'd0};
                        REG_PER_LO: w_res.read_data = r_per[7:0];
                        default:    w_res.read_data = {r_trig, r_gate, 3'd0, r_per[10:8]};
                    endcase
                end else if (w_wave_hit) begin
                    w_res.read_data = w_byte;
                end
            end
            OP_WRITE: begin
                if (w_reg_hit) begin
                    unique case (i_address[3:0])
                        REG_DAC: begin
                            n_dac_on = i_write_data[7];
                            if (!i_write_data[7]) begin
                                n_ch_on = 1'b0;
                            end
                        end
                        REG_LENGTH: n_len = LENGTH_FULL - {1'b0, i_write_data};
                        REG_VOLUME: n_vol = i_write_data[6:5];
                        REG_PER_LO: n_per = {r_per[10:8], i_write_data};
                        default: begin
                            n_gate = i_write_data[6];
                            n_per  = {i_write_data[2:0], r_per[7:0]};
                            n_trig = i_write_data[7];
                            if (i_write_data[7]) begin
                                n_ch_on = 1'b1;
                                if (r_len == 9'd0) begin
                                    n_len = LENGTH_FULL;
                                end
                                w_reload = {PERIOD_BASE - {1'b0, i_write_data[2:0],
                                            r_per[7:0]}, 1'b0};
                                n_timer = w_reload;
                                n_pos   = 5'd0;
                            end
                        end
                    endcase
                end
            end
            OP_SAMPLE: begin
                w_reload = {PERIOD_BASE - {1'b0, r_per}, 1'b0};
                if (r_timer <= 13'd1) begin
                    n_timer = w_reload;
                    n_pos   = w_step_pos;
                end else begin
                    n_timer = r_timer - 13'd1;
                end
                if (r_ch_on && r_dac_on && (r_vol != 2'd0)) begin
                    n_level = w_nib >> w_shift;
                end else begin
                    n_level = 4'd0;
                end
            end
            default: begin
                if (r_gate) begin
                    if (r_len != 9'd0) begin
                        n_len = r_len - 9'd1;
                    end
                    if ((r_len == 9'd0) || (r_len == 9'd1)) begin
                        n_ch_on = 1'b0;
                    end
                end
            end
        endcase

        w_res.sample_level   = n_level;
        w_res.length_running = (n_len != 9'd0);
        w_res.channel_active = n_ch_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dac_on <= 1'b0;
            r_ch_on  <= 1'b0;
            r_len    <= 9'd0;
            r_gate   <= 1'b0;
            r_trig   <= 1'b0;
            r_vol    <= 2'd0;
            r_per    <= 11'd0;
            r_timer  <= 13'd0;
            r_pos    <= 5'd0;
            r_level  <= 4'd0;
        end else if (w_push) begin
            r_dac_on <= n_dac_on;
            r_ch_on  <= n_ch_on;
            r_len    <= n_len;
            r_gate   <= n_gate;
            r_trig   <= n_trig;
            r_vol    <= n_vol;
            r_per    <= n_per;
            r_timer  <= n_timer;
            r_pos    <= n_pos;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WAVE_DEPTH; i++) begin
                r_wave[i] <= 8'd0;
            end
        end else if (w_wave_we) begin
            r_wave[i_address[3:0]] <= i_write_data;
        end
    end

    // output queue: head drives the ports, skid catches a beat while head is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hd_valid <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_sk_valid) begin
                r_hd_valid <= 1'b1;
                r_sk_valid <= w_push;
            end else begin
                r_hd_valid <= w_push;
            end
        end else if (w_push) begin
            if (r_hd_valid) begin
                r_sk_valid <= 1'b1;
            end else begin
                r_hd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_sk_valid) begin
                r_hd <= r_sk;
                r_sk <= w_res;
            end else begin
                r_hd <= w_res;
            end
        end else if (w_push) begin
            if (r_hd_valid) begin
                r_sk <= w_res;
            end else begin
                r_hd <= w_res;
            end
        end
    end

    assign o_out_valid      = r_hd_valid;
    assign o_read_data      = r_hd.read_data;
    assign o_sample_level   = r_hd.sample_level;
    assign o_length_running = r_hd.length_running;
    assign o_channel_active = r_hd.channel_active;

`ifndef SYNTHESIS
    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_hd_valid)
        else $error("skid entry valid while head is empty");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push && !r_sk_valid) |=> !o_out_valid)
        else $error("queue did not empty after last beat left");

    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LENGTH_FULL)
        else $error("length count beyond full length");
`endif

endmodule

FILE: test/tb_wavetable_sound_channel.sv
// testbench for the wavetable sound channel: bus events against a predicted channel state
module tb_wavetable_sound_channel;
    import wsc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int SETTLE       = 8;
    localparam int PHASE_EVENTS = 381;

    typedef struct packed {
        t_op         op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [6:0]  tx_pct;
        logic [6:0]  rx_pct;
        logic        drain;
        logic        hold;
    } t_bus_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_op         i_operation = OP_READ;
    logic [15:0] i_address = '0;
    logic [7:0]  i_write_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_read_data;
    logic [3:0]  o_sample_level;
    logic        o_length_running;
    logic        o_channel_active;

    wavetable_sound_channel u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_address        (i_address),
        .i_write_data     (i_write_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_read_data      (o_read_data),
        .o_sample_level   (o_sample_level),
        .o_length_running (o_length_running),
        .o_channel_active (o_channel_active)
    );

    always #5 i_clk = ~i_clk;

    t_bus_event event_q[$];
    t_result    expected_results[$];
    int         errors = 0;
    int         cycles = 0;
    logic       beat_taken = 1'b0;
    logic [6:0] rx_pct = '0;
    int         hold_reqs = 0;
    int         hold_seen = 0;
    int         hold_left = 0;

    // stimulus build state
    logic [6:0] cur_tx = '0;
    logic [6:0] cur_rx = '0;
    logic       next_drain = 1'b0;
    logic       next_hold = 1'b0;

    // predicted channel state
    logic        ch_dac = 1'b0;
    logic        ch_on = 1'b0;
    logic [8:0]  ch_len = '0;
    logic        ch_gate = 1'b0;
    logic        ch_trig = 1'b0;
    logic [1:0]  ch_vol = '0;
    logic [10:0] ch_period = '0;
    logic [12:0] ch_timer = '0;
    logic [4:0]  ch_pos = '0;
    logic [7:0]  ch_wave [WAVE_DEPTH];
    logic [3:0]  ch_level = '0;

    function automatic t_result channel_step(t_op op, logic [15:0] addr, logic [7:0] d);
        t_result     res;
        logic [7:0]  rd;
        logic [7:0]  b;
        logic [3:0]  nib;
        logic [12:0] reload;
        logic        is_reg;
        logic        is_wave;
        rd      = '0;
        reload  = {1'b0, PERIOD_BASE - {1'b0, ch_period}} << 1;
        is_reg  = addr[15:4] == REG_PAGE && addr[3:0] >= REG_DAC && addr[3:0] <= REG_PER_HI;
        is_wave = addr[15:4] == WAVE_PAGE;
        case (op)
            OP_READ: begin
                if (is_reg) begin
                    case (addr[3:0])
                        REG_DAC:    rd = {ch_dac, 7'd0};
                        REG_LENGTH: rd = 8'(LENGTH_FULL - ch_len);
                        REG_VOLUME: rd = {1'b0, ch_vol, 5'd0};
                        REG_PER_LO: rd = ch_period[7:0];
                        default:    rd = {ch_trig, ch_gate, 3'd0, ch_period[10:8]};
                    endcase
                end else if (is_wave) begin
                    rd = ch_wave[addr[3:0]];
                end
            end
            OP_WRITE: begin
                if (is_reg) begin
                    case (addr[3:0])
                        REG_DAC: begin
                            ch_dac = d[7];
                            if (!d[7])
                                ch_on = 1'b0;
                        end
                        REG_LENGTH: ch_len = LENGTH_FULL - {1'b0, d};
                        REG_VOLUME: ch_vol = d[6:5];
                        REG_PER_LO: ch_period[7:0] = d;
                        default: begin
                            ch_gate = d[6];
                            ch_period[10:8] = d[2:0];
                            ch_trig = d[7];
                            if (d[7]) begin
                                ch_on = 1'b1;
                                if (ch_len == 0)
                                    ch_len = LENGTH_FULL;
                                ch_timer = {1'b0, PERIOD_BASE - {1'b0, ch_period}} << 1;
                                ch_pos = '0;
                            end
                        end
                    endcase
                end else if (is_wave) begin
                    ch_wave[addr[3:0]] = d;
                end
            end
            OP_SAMPLE: begin
                if (ch_timer <= 1) begin
                    ch_timer = reload;
                    ch_pos = ch_pos + 5'd1;
                end else begin
                    ch_timer = ch_timer - 13'd1;
                end
                if (ch_on && ch_dac && ch_vol != 0) begin
                    b = ch_wave[ch_pos[4:1]];
                    nib = ch_pos[0] ? b[3:0] : b[7:4];
                    ch_level = nib >> (ch_vol - 2'd1);
                end else begin
                    ch_level = '0;
                end
            end
            default: begin
                if (ch_gate) begin
                    if (ch_len != 0)
                        ch_len = ch_len - 9'd1;
                    if (ch_len == 0)
                        ch_on = 1'b0;
                end
            end
        endcase
        res.read_data      = rd;
        res.sample_level   = ch_level;
        res.length_running = ch_len != 0;
        res.channel_active = ch_on;
        return res;
    endfunction

    task automatic add_event(t_op op, logic [15:0] addr, logic [7:0] d);
        t_bus_event ev;
        ev.op     = op;
        ev.addr   = addr;
        ev.data   = d;
        ev.tx_pct = cur_tx;
        ev.rx_pct = cur_rx;
        ev.drain  = next_drain;
        ev.hold   = next_hold;
        event_q.push_back(ev);
        next_drain = 1'b0;
        next_hold  = 1'b0;
    endtask

    // mostly register and wave traffic, biased toward short periods and lengths
    task automatic add_random_event();
        int          r;
        t_op         op;
        logic [15:0] addr;
        logic [7:0]  d;
        r = $urandom_range(99);
        if (r < 25)
            op = OP_READ;
        else if (r < 55)
            op = OP_WRITE;
        else if (r < 85)
            op = OP_SAMPLE;
        else
            op = OP_LENGTH;
        r = $urandom_range(99);
        if (r < 45) begin
            addr = {REG_PAGE, REG_DAC} + 16'($urandom_range(4));
        end else if (r < 70) begin
            addr = {WAVE_PAGE, 4'($urandom_range(15))};
        end else if (r < 80) begin
            case ($urandom_range(5))
                0:       addr = {REG_PAGE, REG_DAC} - 16'd1;
                1:       addr = {REG_PAGE, REG_PER_HI} + 16'd1;
                2:       addr = {WAVE_PAGE, 4'h0} - 16'd1;
                3:       addr = {WAVE_PAGE, 4'hF} + 16'd1;
                4:       addr = 16'h0000;
                default: addr = 16'hFFFF;
            endcase
        end else begin
            addr = 16'($urandom());
        end
        d = 8'($urandom());
        if (addr == {REG_PAGE, REG_PER_HI} && $urandom_range(99) < 70)
            d[2:0] = 3'b111;
        if (addr == {REG_PAGE, REG_PER_LO} && $urandom_range(99) < 70)
            d[7:5] = 3'b111;
        if (addr == {REG_PAGE, REG_DAC} && $urandom_range(99) < 75)
            d[7] = 1'b1;
        if (addr == {REG_PAGE, REG_LENGTH} && $urandom_range(99) < 50)
            d[7:4] = 4'hF;
        add_event(op, addr, d);
    endtask

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            errors = errors + 1;
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // sender: holds a beat until taken, otherwise pops the next pending event or idles (empty, drain wait, random gap)
    always @(negedge i_clk) begin : event_driver
        t_bus_event ev;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || beat_taken) begin
            if (event_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (event_q[0].drain && expected_results.size() != 0) begin
                i_in_valid <= 1'b0;
            end else if ($urandom_range(99) < event_q[0].tx_pct) begin
                i_in_valid <= 1'b0;
            end else begin
                ev = event_q.pop_front();
                i_operation  <= ev.op;
                i_address    <= ev.addr;
                i_write_data <= ev.data;
                i_in_valid   <= 1'b1;
                rx_pct       <= ev.rx_pct;
                if (ev.hold)
                    hold_reqs <= hold_reqs + 1;
            end
        end
    end

    // receiver stall, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen   <= hold_seen + 1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= $urandom_range(99) < rx_pct;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result exp_r;
        if (!i_rst_n) begin
            beat_taken <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result read_data %0h level %0h len %0b on %0b",
                             $time, o_read_data, o_sample_level, o_length_running,
                             o_channel_active);
                    errors = errors + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("read_data", exp_r.read_data, o_read_data);
                    check_field("sample_level", exp_r.sample_level, o_sample_level);
                    check_field("length_running", exp_r.length_running, o_length_running);
                    check_field("channel_active", exp_r.channel_active, o_channel_active);
                end
            end
            beat_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall)
                expected_results.push_back(channel_step(i_operation, i_address, i_write_data));
        end
    end

    initial begin
        for (int i = 0; i < WAVE_DEPTH; i++)
            ch_wave[i] = '0;

        // directed: reset values, wave ram edges, trigger, volume codes, length expiry
        add_event(OP_READ,   {REG_PAGE, REG_DAC}, 8'h00);
        add_event(OP_READ,   {REG_PAGE, REG_LENGTH}, 8'hFF);
        add_event(OP_WRITE,  {WAVE_PAGE, 4'h0}, 8'hF1);
        add_event(OP_WRITE,  {WAVE_PAGE, 4'h1}, 8'h2E);
        add_event(OP_WRITE,  {WAVE_PAGE, 4'hF}, 8'hA5);
        add_event(OP_READ,   {WAVE_PAGE, 4'hF}, 8'h00);
        add_event(OP_WRITE,  {REG_PAGE, REG_DAC}, 8'h80);
        add_event(OP_WRITE,  {REG_PAGE, REG_VOLUME}, 8'h20);
        add_event(OP_WRITE,  {REG_PAGE, REG_PER_LO}, 8'hFF);
        // trigger with length zero loads a full count, read of full count gives zero
        add_event(OP_WRITE,  {REG_PAGE, REG_PER_HI}, 8'hC7);
        add_event(OP_READ,   {REG_PAGE, REG_LENGTH}, 8'h00);
        add_event(OP_READ,   {REG_PAGE, REG_PER_HI}, 8'h00);
        add_event(OP_SAMPLE, 16'hFFFF, 8'hFF);
        add_event(OP_SAMPLE, 16'h0000, 8'h00);
        add_event(OP_WRITE,  {REG_PAGE, REG_VOLUME}, 8'h60);
        add_event(OP_SAMPLE, 16'h0000, 8'h00);
        add_event(OP_SAMPLE, 16'h0000, 8'h00);
        add_event(OP_WRITE,  {REG_PAGE, REG_VOLUME}, 8'h40);
        add_event(OP_SAMPLE, 16'h0000, 8'h00);
        add_event(OP_WRITE,  {REG_PAGE, REG_LENGTH}, 8'hFF);
        add_event(OP_LENGTH, 16'h0000, 8'h00);
        add_event(OP_LENGTH, 16'hFFFF, 8'hFF);
        add_event(OP_WRITE,  {REG_PAGE, REG_PER_HI}, 8'h80);
        add_event(OP_WRITE,  {REG_PAGE, REG_DAC}, 8'h00);
        add_event(OP_WRITE,  {REG_PAGE, REG_PER_HI} + 16'd1, 8'hFF);
        add_event(OP_READ,   {REG_PAGE, REG_DAC} - 16'd1, 8'h00);

        // long receiver hold-off while the sender keeps offering
        next_hold = 1'b1;
        for (int i = 0; i < PHASE_EVENTS; i++)
            add_random_event();

        for (int p = 1; p < 4; p++) begin
            cur_tx = (p == 1) ? 7'd45 : (p == 3) ? 7'd25 : 7'd0;
            cur_rx = (p == 2) ? 7'd45 : (p == 3) ? 7'd25 : 7'd0;
            next_drain = 1'b1;
            for (int i = 0; i < PHASE_EVENTS; i++)
                add_random_event();
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (event_q.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
rtl/wsc_pkg.sv
rtl/wavetable_sound_channel.sv
test/tb_wavetable_sound_channel.sv
